// ===== src/mosaic_slice_address_map_assert.svh =====
// Assertion macros for the mosaic slice address map.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef MOSAIC_SLICE_ADDRESS_MAP_ASSERT_SVH
`define MOSAIC_SLICE_ADDRESS_MAP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define MSAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define MSAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/msam_pkg.sv =====
// Shared types and constants of the mosaic slice address map.
// No dependencies.
package msam_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EFF_W      = 12;
  localparam int SLC_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_READ_RES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_RES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

endpackage

// ===== src/msam_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Stand-alone; carries a sideband vector alongside the operands.
module msam_div_pipe #(
  parameter int NW  = 24,
  parameter int DW  = 20,
  parameter int SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           out_valid_o,
  output logic [NW-1:0]  quo_o,
  output logic [DW-1:0]  rem_o,
  output logic [SBW-1:0] sb_o
);

  logic [NW-1:0]           vld_q;
  logic [NW-1:0][NW-1:0]   num_q;
  logic [NW-1:0][DW-1:0]   den_q;
  logic [NW-1:0][DW-1:0]   rem_q;
  logic [NW-1:0][NW-1:0]   quo_q;
  logic [NW-1:0][SBW-1:0]  sb_q;

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic           v_in;
    logic [NW-1:0]  n_in;
    logic [DW-1:0]  d_in;
    logic [DW-1:0]  r_in;
    logic [NW-1:0]  q_in;
    logic [SBW-1:0] s_in;
    logic [DW:0]    trial;
    logic [DW:0]    diff;
    logic           ge;
    logic [DW-1:0]  rem_d;
    logic [NW-1:0]  quo_d;

    if (g == 0) begin : g_first
      assign v_in = in_valid_i;
      assign n_in = num_i;
      assign d_in = den_i;
      assign r_in = '0;
      assign q_in = '0;
      assign s_in = sb_i;
    end else begin : g_next
      assign v_in = vld_q[g-1];
      assign n_in = num_q[g-1];
      assign d_in = den_q[g-1];
      assign r_in = rem_q[g-1];
      assign q_in = quo_q[g-1];
      assign s_in = sb_q[g-1];
    end

    always_comb begin
      trial = {r_in, n_in[NW-1-g]};
      diff  = trial - {1'b0, d_in};
      ge    = (trial >= {1'b0, d_in});
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = q_in;
      quo_d[NW-1-g] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[g] <= n_in;
      den_q[g] <= d_in;
      rem_q[g] <= rem_d;
      quo_q[g] <= quo_d;
      sb_q[g]  <= s_in;
    end
  end

  assign out_valid_o = vld_q[NW-1];
  assign quo_o       = quo_q[NW-1];
  assign rem_o       = rem_q[NW-1];
  assign sb_o        = sb_q[NW-1];

endmodule

// ===== src/msam_sqrt_pipe.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Stand-alone; carries a sideband vector alongside the operand.
module msam_sqrt_pipe #(
  parameter int IW  = 24,
  parameter int SBW = 1,
  localparam int RW = (IW + 1) / 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [IW-1:0]  rad_i,
  input  logic [SBW-1:0] sb_i,
  output logic           out_valid_o,
  output logic [RW-1:0]  root_o,
  output logic           exact_o,
  output logic [SBW-1:0] sb_o
);

  logic [RW-1:0]                vld_q;
  logic [RW-1:0][2*RW-1:0]      rad_q;
  logic [RW-1:0][RW+1:0]        rem_q;
  logic [RW-1:0][RW-1:0]        root_q;
  logic [RW-1:0][SBW-1:0]       sb_q;

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic            v_in;
    logic [2*RW-1:0] x_in;
    logic [RW+1:0]   r_in;
    logic [RW-1:0]   q_in;
    logic [SBW-1:0]  s_in;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   sub;
    logic            ge;
    logic [RW+3:0]   diff;
    logic [RW+1:0]   rem_d;
    logic [RW-1:0]   root_d;

    if (g == 0) begin : g_first
      assign v_in = in_valid_i;
      assign x_in = (2*RW)'(rad_i);
      assign r_in = '0;
      assign q_in = '0;
      assign s_in = sb_i;
    end else begin : g_next
      assign v_in = vld_q[g-1];
      assign x_in = rad_q[g-1];
      assign r_in = rem_q[g-1];
      assign q_in = root_q[g-1];
      assign s_in = sb_q[g-1];
    end

    always_comb begin
      trial  = {r_in, x_in[2*RW-1-2*g -: 2]};
      sub    = {2'b00, q_in, 2'b01};
      ge     = (trial >= sub);
      diff   = trial - sub;
      rem_d  = ge ? diff[RW+1:0] : trial[RW+1:0];
      root_d = {q_in[RW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[g]  <= x_in;
      rem_q[g]  <= rem_d;
      root_q[g] <= root_d;
      sb_q[g]   <= s_in;
    end
  end

  assign out_valid_o = vld_q[RW-1];
  assign root_o      = root_q[RW-1];
  assign exact_o     = (rem_q[RW-1] == '0);
  assign sb_o        = sb_q[RW-1];

endmodule

// ===== src/mosaic_slice_address_map.sv =====
// Mosaic slice address map: top level.
// Uses msam_pkg, msam_div_pipe, msam_sqrt_pipe and the assertion macro header.
//
// Takes one transaction per clock, every clock: busy_o never rises. Each
// result passes the capture register, a divider of the pixel count by
// read_res*phase_res, the stage B register, a square-root unit, the stage C
// register, a divider that splits the in-slice offset into row and column,
// the M1 and M2 registers and the output register before it leaves on done_o.
// The pipeline never holds, so results cannot be stalled and must be taken
// in the cycle they appear.
// Configuration writes are always accepted; write only while no transaction
// is in flight, and allow two cycles before the next start_i.
module mosaic_slice_address_map #(
  parameter int PIXEL_INDEX_BITS = 24,
  parameter int DIM_BITS         = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [PIXEL_INDEX_BITS-1:0]     mosaic_pixels_i,
  input  logic [PIXEL_INDEX_BITS-1:0]     out_index_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [msam_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msam_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            done_o,
  output logic [PIXEL_INDEX_BITS-1:0]     src_index_o,
  output logic [1:0]                      status_o,
  output logic [msam_pkg::EFF_W-1:0]      eff_read_res_o,
  output logic [msam_pkg::EFF_W-1:0]      eff_phase_res_o,
  output logic [msam_pkg::SLC_W-1:0]      eff_slices_o
);
  import msam_pkg::*;

  localparam int P       = PIXEL_INDEX_BITS;
  localparam int D       = DIM_BITS;
  localparam int RW      = (P + 1) / 2;
  localparam int VW      = 2 * D + SLC_W;
  localparam int CW      = (P > VW) ? P : VW;
  localparam int LATENCY = P + RW + 2 * D + 5;

  // ---------------------------------------------------------------------------
  // Configuration registers and derived products
  // ---------------------------------------------------------------------------
  logic [D-1:0]     read_res_q;
  logic [D-1:0]     phase_res_q;
  logic [SLC_W-1:0] slice_count_q;
  logic [2*D-1:0]   rp_q;
  logic [VW-1:0]    vol_q;
  logic             cfg_wr;
  logic             fallback;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Writes to indexes past the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_res_q    <= '0;
      phase_res_q   <= '0;
      slice_count_q <= '0;
      rp_q          <= '0;
      vol_q         <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index_i)
          CFG_READ_RES:    read_res_q    <= cfg_data_i[D-1:0];
          CFG_PHASE_RES:   phase_res_q   <= cfg_data_i[D-1:0];
          CFG_SLICE_COUNT: slice_count_q <= cfg_data_i[SLC_W-1:0];
          default: ;
        endcase
      end
      // Tile area is registered from the config registers, and slice-stack volume from the registered area.
      rp_q  <= (2*D)'(read_res_q) * (2*D)'(phase_res_q);
      vol_q <= VW'(rp_q) * VW'(slice_count_q);
    end
  end

  // Any unknown dimension switches to the single square slice mapping.
  assign fallback = (read_res_q == '0) || (phase_res_q == '0) || (slice_count_q == '0);

  // ---------------------------------------------------------------------------
  // Stage 0: capture the transaction
  // ---------------------------------------------------------------------------
  logic         vld0_q;
  logic [P-1:0] pix0_q;
  logic [P-1:0] idx0_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    pix0_q <= mosaic_pixels_i;
    idx0_q <= out_index_i;
  end

  // ---------------------------------------------------------------------------
  // Phase 1: tiles = pixels / rp and slice number = index / rp, side by side
  // ---------------------------------------------------------------------------
  logic           vld1a;
  logic           vld1b;
  logic [P-1:0]   tiles1;
  logic [2*D-1:0] pixrem1;
  logic [P-1:0]   pix1;
  logic [P-1:0]   n1;
  logic [2*D-1:0] off1;
  logic [P-1:0]   idx1;

  msam_div_pipe #(.NW(P), .DW(2*D), .SBW(P)) u_div_tiles (
    .clk_i, .rst_ni,
    .in_valid_i (vld0_q),
    .num_i      (pix0_q),
    .den_i      (rp_q),
    .sb_i       (pix0_q),
    .out_valid_o(vld1a),
    .quo_o      (tiles1),
    .rem_o      (pixrem1),
    .sb_o       (pix1)
  );

  msam_div_pipe #(.NW(P), .DW(2*D), .SBW(P)) u_div_slice (
    .clk_i, .rst_ni,
    .in_valid_i (vld0_q),
    .num_i      (idx0_q),
    .den_i      (rp_q),
    .sb_i       (idx0_q),
    .out_valid_o(vld1b),
    .quo_o      (n1),
    .rem_o      (off1),
    .sb_o       (idx1)
  );

  // ---------------------------------------------------------------------------
  // Stage B: mosaic checks that need no root, and the range check
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [P-1:0]     idx;
    logic [SLC_W-1:0] n;
    logic [2*D-1:0]   off;
    logic             exact;
    logic             sl_ok;
    logic             in_vol;
  } stb_t;

  logic         vldb_q;
  logic [P-1:0] rad_q;
  stb_t         stb_q;
  stb_t         stb_d;
  logic [P-1:0] rad_d;

  always_comb begin
    stb_d.idx   = idx1;
    stb_d.n     = n1[SLC_W-1:0];
    stb_d.off   = off1;
    stb_d.exact = (pixrem1 == '0);
    stb_d.sl_ok = (P'(slice_count_q) <= tiles1);
    if (fallback) begin
      stb_d.in_vol = (idx1 < pix1);
      rad_d        = pix1;
    end else begin
      stb_d.in_vol = (CW'(idx1) < CW'(vol_q));
      rad_d        = tiles1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldb_q <= 1'b0;
    end else begin
      vldb_q <= vld1a && vld1b;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    stb_q <= stb_d;
  end

  // ---------------------------------------------------------------------------
  // Phase 2: tile grid width (or fallback slice side) as a square root
  // ---------------------------------------------------------------------------
  logic          vld2;
  logic [RW-1:0] root2;
  logic          sq2;
  logic [$bits(stb_t)-1:0] stb2_vec;
  stb_t          stb2;

  msam_sqrt_pipe #(.IW(P), .SBW($bits(stb_t))) u_sqrt (
    .clk_i, .rst_ni,
    .in_valid_i (vldb_q),
    .rad_i      (rad_q),
    .sb_i       (stb_q),
    .out_valid_o(vld2),
    .root_o     (root2),
    .exact_o    (sq2),
    .sb_o       (stb2_vec)
  );

  assign stb2 = stb_t'(stb2_vec);

  // ---------------------------------------------------------------------------
  // Stage C: decide the match, then split offset and slice number
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [P-1:0] idx;
    logic         ok;
    logic         in_vol;
  } stc_t;

  logic           vldc_q;
  logic [RW-1:0]  rootc_q;
  logic [2*D-1:0] offc_q;
  logic [SLC_W-1:0] nc_q;
  stc_t           stc_q;
  stc_t           stc_d;

  always_comb begin
    stc_d.idx    = stb2.idx;
    stc_d.in_vol = stb2.in_vol;
    stc_d.ok     = fallback ? sq2 : (sq2 && stb2.exact && stb2.sl_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldc_q <= 1'b0;
    end else begin
      vldc_q <= vld2;
    end
  end

  always_ff @(posedge clk_i) begin
    rootc_q <= root2;
    offc_q  <= stb2.off;
    nc_q    <= stb2.n;
    stc_q   <= stc_d;
  end

  // ---------------------------------------------------------------------------
  // Phase 3: row/column inside the tile, tile row/column inside the grid
  // ---------------------------------------------------------------------------
  logic           vld3a;
  logic           vld3b;
  logic [2*D-1:0] row3;
  logic [D-1:0]   col3;
  logic [2*D-1:0] ti3;
  logic [RW-1:0]  tj3;
  logic [$bits(stc_t)-1:0] stc3_vec;
  stc_t           stc3;
  logic [RW-1:0]  w3;

  msam_div_pipe #(.NW(2*D), .DW(D), .SBW($bits(stc_t))) u_div_rowcol (
    .clk_i, .rst_ni,
    .in_valid_i (vldc_q),
    .num_i      (offc_q),
    .den_i      (read_res_q),
    .sb_i       (stc_q),
    .out_valid_o(vld3a),
    .quo_o      (row3),
    .rem_o      (col3),
    .sb_o       (stc3_vec)
  );

  msam_div_pipe #(.NW(2*D), .DW(RW), .SBW(RW)) u_div_tile (
    .clk_i, .rst_ni,
    .in_valid_i (vldc_q),
    .num_i      ((2*D)'(nc_q)),
    .den_i      (rootc_q),
    .sb_i       (rootc_q),
    .out_valid_o(vld3b),
    .quo_o      (ti3),
    .rem_o      (tj3),
    .sb_o       (w3)
  );

  assign stc3 = stc_t'(stc3_vec);

  // ---------------------------------------------------------------------------
  // M1: grid strides ph*w and w*rd; all sums wrap at the index width
  // ---------------------------------------------------------------------------
  logic         vldm1_q;
  logic [P-1:0] phw_q;
  logic [P-1:0] wrd_q;
  logic [P-1:0] tim1_q;
  logic [P-1:0] tjm1_q;
  logic [P-1:0] rowm1_q;
  logic [P-1:0] colm1_q;
  logic [RW-1:0] wm1_q;
  stc_t         stm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldm1_q <= 1'b0;
    end else begin
      vldm1_q <= vld3a && vld3b;
    end
  end

  always_ff @(posedge clk_i) begin
    phw_q   <= P'(phase_res_q) * P'(w3);
    wrd_q   <= P'(w3) * P'(read_res_q);
    tim1_q  <= P'(ti3);
    tjm1_q  <= P'(tj3);
    rowm1_q <= P'(row3);
    colm1_q <= P'(col3);
    wm1_q   <= w3;
    stm1_q  <= stc3;
  end

  // ---------------------------------------------------------------------------
  // M2: tile base in rows of tiles and row offset within the grid
  // ---------------------------------------------------------------------------
  logic         vldm2_q;
  logic [P-1:0] tbase_q;
  logic [P-1:0] rowoff_q;
  logic [RW-1:0] wm2_q;
  stc_t         stm2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldm2_q <= 1'b0;
    end else begin
      vldm2_q <= vldm1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tbase_q  <= phw_q * tim1_q + tjm1_q;
    rowoff_q <= wrd_q * rowm1_q + colm1_q;
    wm2_q    <= wm1_q;
    stm2_q   <= stm1_q;
  end

  // ---------------------------------------------------------------------------
  // Output stage: scale tile base by row length, pick status and widths
  // ---------------------------------------------------------------------------
  logic             done_q;
  logic [P-1:0]     src_q;
  status_e          status_q;
  logic [EFF_W-1:0] effr_q;
  logic [EFF_W-1:0] effp_q;
  logic [SLC_W-1:0] effs_q;

  logic [P-1:0]     src_d;
  status_e          status_d;
  logic [EFF_W-1:0] effr_d;
  logic [EFF_W-1:0] effp_d;
  logic [SLC_W-1:0] effs_d;

  always_comb begin
    if (fallback) begin
      src_d  = stm2_q.idx;
      effr_d = EFF_W'(wm2_q);
      effp_d = EFF_W'(wm2_q);
      effs_d = SLC_W'(1);
    end else begin
      src_d  = P'(read_res_q) * tbase_q + rowoff_q;
      effr_d = EFF_W'(read_res_q);
      effp_d = EFF_W'(phase_res_q);
      effs_d = slice_count_q;
    end
    status_d = STATUS_OK;
    if (!stm2_q.ok) begin
      status_d = STATUS_MISMATCH;
      src_d    = '0;
      effr_d   = '0;
      effp_d   = '0;
      effs_d   = '0;
    end else if (!stm2_q.in_vol) begin
      status_d = STATUS_RANGE;
      src_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vldm2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    status_q <= status_d;
    effr_q   <= effr_d;
    effp_q   <= effp_d;
    effs_q   <= effs_d;
  end

  assign done_o          = done_q;
  assign src_index_o     = src_q;
  assign status_o        = status_q;
  assign eff_read_res_o  = effr_q;
  assign eff_phase_res_o = effp_q;
  assign eff_slices_o    = effs_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "mosaic_slice_address_map_assert.svh"

  `MSAM_ASSERT_IMP(a_done_latency, done_o, $past(start_i, LATENCY + 1), "result without start")
  `MSAM_ASSERT_IMP(a_mismatch_zero, done_o && (status_o == STATUS_MISMATCH), (src_index_o == '0) && (eff_read_res_o == '0) && (eff_phase_res_o == '0) && (eff_slices_o == '0), "mismatch result not cleared")
  `MSAM_ASSERT_IMP(a_range_zero, done_o && (status_o == STATUS_RANGE), src_index_o == '0, "range result carries an index")
  `MSAM_ASSERT(a_lanes_aligned, (vld1a == vld1b) && (vld3a == vld3b), "parallel units out of step")

endmodule
